[rtl/core/kvlp_pkg.sv]
// ----------------------------------------------------------------------------
// kvlp_pkg
// Shared constants, types and helpers for the key/value line parser.
// ----------------------------------------------------------------------------
package kvlp_pkg;

    // Parameter defaults
    localparam int NAME_MAX_DEF       = 7;
    localparam int FILE_VALUE_MAX_DEF = 63;
    localparam int TYPE_VALUE_MAX_DEF = 15;

    // Characters
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SEMI  = 8'd59;
    localparam logic [7:0] CH_EQ    = 8'd61;
    localparam logic [7:0] CH_BLANK = 8'd32;
    localparam logic [7:0] CH_LO_A  = 8'd97;
    localparam logic [7:0] CH_LO_Z  = 8'd122;
    localparam logic [7:0] CASE_OFS = 8'd32;

    // Parse phases
    localparam int          PH_W       = 4;
    localparam logic [PH_W-1:0] PH_BEGIN   = 4'd0;
    localparam logic [PH_W-1:0] PH_PRE     = 4'd1;
    localparam logic [PH_W-1:0] PH_GET     = 4'd2;
    localparam logic [PH_W-1:0] PH_POST    = 4'd3;
    localparam logic [PH_W-1:0] PH_MATCH   = 4'd4;
    localparam logic [PH_W-1:0] PH_VPRE    = 4'd5;
    localparam logic [PH_W-1:0] PH_VGET    = 4'd6;
    localparam logic [PH_W-1:0] PH_VPOST   = 4'd7;
    localparam logic [PH_W-1:0] PH_COMMENT = 4'd8;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FORMAT  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // Keywords
    localparam int KW_LEN = 4;
    localparam int KW_IW  = 2;
    localparam logic KEY_FILE = 1'b0;
    localparam logic KEY_TYPE = 1'b1;

    typedef logic [KW_LEN-1:0][7:0] name_t;

    typedef struct packed {
        logic [PH_W-1:0] phase;
        logic [5:0]      value_count;
        logic            current_key;
        logic [1:0]      error_code;
    } parse_state_t;

    typedef struct packed {
        logic             we;
        logic [KW_IW-1:0] idx;
        logic [7:0]       data;
    } name_wr_t;

    typedef struct packed {
        logic [1:0] status;
        logic       key_cleared;
        logic       key_index;
        logic       char_valid;
        logic [5:0] char_pos;
        logic [7:0] char_out;
        logic       line_done;
    } result_t;

    function automatic logic [7:0] fold_up(input logic [7:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) ? c - CASE_OFS : c;
    endfunction

    function automatic logic [7:0] kw_char(input logic k, input int i);
        logic [7:0] c;
        c = 8'd0;
        case (i)
            0: c = k ? "T" : "F";
            1: c = k ? "Y" : "I";
            2: c = k ? "P" : "L";
            3: c = "E";
            default: c = 8'd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/core/kvlp_step.sv]
// ----------------------------------------------------------------------------
// kvlp_step
// Next-state and result logic for one text byte.
// ----------------------------------------------------------------------------
module kvlp_step
    import kvlp_pkg::*;
#(
    parameter int NAME_MAX       = NAME_MAX_DEF,
    parameter int FILE_VALUE_MAX = FILE_VALUE_MAX_DEF,
    parameter int TYPE_VALUE_MAX = TYPE_VALUE_MAX_DEF,
    localparam int NCW           = $clog2(NAME_MAX + 1)
)
(
    input  logic [7:0]   ch,
    input  parse_state_t st,
    input  logic [NCW-1:0] name_count,
    input  name_t        name_chars,
    output parse_state_t st_next,
    output logic [NCW-1:0] name_count_next,
    output name_wr_t     name_wr,
    output result_t      res
);

    logic            stop;
    logic            cleared;
    logic            cvalid;
    logic            done;
    logic [5:0]      pos;
    logic [7:0]      cout;
    logic [PH_W-1:0] ph;
    logic [5:0]      lim;
    logic [1:0]      kw_hit;

    // keyword compare on the stored name
    always_comb
    begin
        for (int k = 0; k < 2; k++)
        begin
            kw_hit[k] = (name_count == NCW'(KW_LEN));
            for (int i = 0; i < KW_LEN; i++)
            begin
                if (fold_up(name_chars[i]) != kw_char(k[0], i))
                begin
                    kw_hit[k] = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        st_next         = st;
        name_count_next = name_count;
        name_wr         = '0;
        stop            = 1'b0;
        cleared         = 1'b0;
        cvalid          = 1'b0;
        done            = 1'b0;
        pos             = 6'd0;
        cout            = 8'd0;
        ph              = st.phase;
        lim             = st.current_key ? 6'(TYPE_VALUE_MAX) : 6'(FILE_VALUE_MAX);

        if (st.error_code != ST_OK)
        begin
            stop = 1'b1;
        end
        if (!stop && ph > PH_COMMENT)
        begin
            ph = PH_BEGIN;
        end
        if (!stop && ph == PH_COMMENT)
        begin
            if (ch == CH_CR)
            begin
                ph = PH_BEGIN;
            end
            stop = 1'b1;
        end
        if (!stop && ph == PH_BEGIN)
        begin
            ph              = PH_PRE;
            name_count_next = '0;
        end
        if (!stop && ph == PH_PRE)
        begin
            if (ch == CH_CR)
            begin
                ph   = PH_BEGIN;
                stop = 1'b1;
            end
            else if (ch == CH_SEMI)
            begin
                ph   = PH_COMMENT;
                stop = 1'b1;
            end
            else if (ch > CH_BLANK)
            begin
                ph = PH_GET;
            end
        end
        if (!stop && ph == PH_GET)
        begin
            if (ch == CH_CR)
            begin
                st_next.error_code = ST_FORMAT;
                stop               = 1'b1;
            end
            else if (ch <= CH_BLANK)
            begin
                ph = PH_POST;
            end
            else if (ch == CH_EQ)
            begin
                ph   = PH_MATCH;
                stop = 1'b1;
            end
            else
            begin
                // only the first keyword-length characters can take part in a match
                if (name_count_next < NCW'(NAME_MAX))
                begin
                    if (name_count_next < NCW'(KW_LEN))
                    begin
                        name_wr.we   = 1'b1;
                        name_wr.idx  = name_count_next[KW_IW-1:0];
                        name_wr.data = ch;
                    end
                    name_count_next = name_count_next + NCW'(1);
                end
                stop = 1'b1;
            end
        end
        if (!stop && ph == PH_POST)
        begin
            if (ch == CH_CR)
            begin
                st_next.error_code = ST_FORMAT;
                stop               = 1'b1;
            end
            else if (ch == CH_EQ)
            begin
                ph   = PH_MATCH;
                stop = 1'b1;
            end
            else if (ch > CH_BLANK)
            begin
                st_next.error_code = ST_FORMAT;
                stop               = 1'b1;
            end
        end
        if (!stop && ph == PH_MATCH)
        begin
            st_next.value_count = 6'd0;
            ph                  = PH_VPRE;
            if (kw_hit[0])
            begin
                st_next.current_key = KEY_FILE;
            end
            else if (kw_hit[1])
            begin
                st_next.current_key = KEY_TYPE;
            end
            else
            begin
                st_next.error_code = ST_UNKNOWN;
                stop               = 1'b1;
            end
            if (!stop)
            begin
                cleared = 1'b1;
                lim     = st_next.current_key ? 6'(TYPE_VALUE_MAX) : 6'(FILE_VALUE_MAX);
            end
        end
        if (!stop && ph == PH_VPRE)
        begin
            if (ch == CH_CR)
            begin
                done = 1'b1;
            end
            else if (ch <= CH_BLANK)
            begin
                stop = 1'b1;
            end
            else
            begin
                ph = PH_VGET;
            end
        end
        if (!stop && ph == PH_VGET && !done)
        begin
            if (ch == CH_CR)
            begin
                done = 1'b1;
            end
            else if (ch <= CH_BLANK)
            begin
                ph = PH_VPOST;
            end
            else if (st_next.value_count < lim)
            begin
                cvalid              = 1'b1;
                pos                 = st_next.value_count;
                cout                = ch;
                st_next.value_count = st_next.value_count + 6'd1;
            end
        end
        if (!stop && ph == PH_VPOST && !done)
        begin
            if (ch == CH_CR)
            begin
                done = 1'b1;
            end
            else if (ch > CH_BLANK)
            begin
                st_next.error_code = ST_FORMAT;
                stop               = 1'b1;
            end
        end
        if (!stop && done)
        begin
            ph = PH_BEGIN;
        end

        st_next.phase   = ph;
        res.status      = st_next.error_code;
        res.key_cleared = cleared;
        res.key_index   = (cleared || cvalid || done) ? st_next.current_key : 1'b0;
        res.char_valid  = cvalid;
        res.char_pos    = pos;
        res.char_out    = cout;
        res.line_done   = done;
    end

endmodule

[rtl/core/key_value_line_parser_unit.sv]
// ----------------------------------------------------------------------------
// key_value_line_parser_unit
// Byte-serial parser for "KEY = VALUE" text lines with FILE and TYPE keys.
// ----------------------------------------------------------------------------
// Takes one text byte per word and returns exactly one result word per byte.
// A byte is captured in an input register, parsed combinationally against
// the line state, and the result lands in an output register once the last
// result has gone out; a new byte can be taken in every cycle while the
// output side keeps up. The combinational parse step, including the
// four-character keyword compare, sets that rate.
// Once status reports an error, every later byte returns only that status.
module key_value_line_parser_unit
    import kvlp_pkg::*;
#(
    parameter int NAME_MAX       = NAME_MAX_DEF,
    parameter int FILE_VALUE_MAX = FILE_VALUE_MAX_DEF,
    parameter int TYPE_VALUE_MAX = TYPE_VALUE_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] status,
    output logic       key_cleared,
    output logic       key_index,
    output logic       char_valid,
    output logic [5:0] char_pos,
    output logic [7:0] char_out,
    output logic       line_done
);

    localparam int NCW = $clog2(NAME_MAX + 1);

    logic           byte_valid_reg;
    logic [7:0]     byte_reg;
    parse_state_t   st_reg;
    parse_state_t   st_next;
    logic [NCW-1:0] name_count_reg;
    logic [NCW-1:0] name_count_next;
    name_t          name_reg;
    name_wr_t       name_wr;
    result_t        res_next;
    result_t        res_reg;
    logic           out_valid_reg;
    logic           fire;

    assign fire     = byte_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !byte_valid_reg || fire;

    kvlp_step #(
        .NAME_MAX       (NAME_MAX),
        .FILE_VALUE_MAX (FILE_VALUE_MAX),
        .TYPE_VALUE_MAX (TYPE_VALUE_MAX)
    ) u_step (
        .ch              (byte_reg),
        .st              (st_reg),
        .name_count      (name_count_reg),
        .name_chars      (name_reg),
        .st_next         (st_next),
        .name_count_next (name_count_next),
        .name_wr         (name_wr),
        .res             (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            st_reg         <= '{phase: PH_BEGIN, value_count: 6'd0,
                                current_key: KEY_FILE, error_code: ST_OK};
            name_count_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                byte_valid_reg <= in_valid;
            end
            if (fire)
            begin
                out_valid_reg  <= 1'b1;
                st_reg         <= st_next;
                name_count_reg <= name_count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg <= in_byte;
        end
        if (fire)
        begin
            res_reg <= res_next;
            if (name_wr.we)
            begin
                name_reg[name_wr.idx] <= name_wr.data;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_reg.status;
    assign key_cleared = res_reg.key_cleared;
    assign key_index   = res_reg.key_index;
    assign char_valid  = res_reg.char_valid;
    assign char_pos    = res_reg.char_pos;
    assign char_out    = res_reg.char_out;
    assign line_done   = res_reg.line_done;

endmodule

[verif/key_value_line_parser_unit_test.sv]
// ----------------------------------------------------------------------------
// key_value_line_parser_unit_test
// Self-checking bench for the key/value line parser.
// ----------------------------------------------------------------------------
// Feeds text bytes through the input handshake and predicts every result
// word from a line-level model of the parser. The model state covers phase,
// name, value count, key and sticky status. The stimulus starts with a few
// directed lines: a comment, an empty line, an empty value and high bytes.
// The bulk is random well-formed FILE/TYPE lines with random case, blanks,
// comments and over-long values. One error sequence, picked at random,
// closes the run. Sticky status is then checked on random noise. Both sides
// stall in random bursts, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module key_value_line_parser_unit_test
    import kvlp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 80;
    localparam int RANDOM_BYTES   = 1300;
    localparam int QUIET_AFTER    = 1150;
    localparam int TAIL_NOISE     = 20;
    localparam int DRAIN_CYCLES   = 10;

    // Error sequences for the end of the run (status is sticky)
    typedef enum int {
        BAD_CR_IN_NAME,
        BAD_TEXT_AFTER_NAME,
        BAD_TEXT_AFTER_VALUE,
        BAD_CR_BEFORE_EQ,
        BAD_UNKNOWN_KEY,
        BAD_LONG_NAME,
        BAD_EMPTY_NAME
    } fault_kind_e;

    class parser_scoreboard;
        logic [PH_W-1:0] phase;
        logic [7:0]      name_buf [NAME_MAX_DEF];
        int              name_cnt;
        int              val_cnt;
        logic            key;
        logic [1:0]      err;
        result_t         due_q [$];
        int              mismatches;
        int              n_bytes;
        int              n_clears;
        int              n_chars;
        int              n_lines;

        function new();
            phase      = PH_BEGIN;
            name_cnt   = 0;
            val_cnt    = 0;
            key        = KEY_FILE;
            err        = ST_OK;
            mismatches = 0;
            n_bytes    = 0;
            n_clears   = 0;
            n_chars    = 0;
            n_lines    = 0;
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        endtask

        function bit name_is(string kw);
            logic [7:0] c;
            if (name_cnt != KW_LEN)
                return 1'b0;
            for (int i = 0; i < KW_LEN; i++)
            begin
                c = name_buf[i];
                if (c >= CH_LO_A && c <= CH_LO_Z)
                    c = c - CASE_OFS;
                if (c != kw[i])
                    return 1'b0;
            end
            return 1'b1;
        endfunction

        // Advance the line state by one byte and return the word it yields
        function result_t parse_byte(logic [7:0] ch);
            result_t r;
            bit      stop;
            bit      clr;
            bit      cv;
            bit      fin;
            int      lim;
            r    = '0;
            stop = (err != ST_OK);
            clr  = 1'b0;
            cv   = 1'b0;
            fin  = 1'b0;
            if (!stop && phase > PH_COMMENT)
                phase = PH_BEGIN;
            if (!stop && phase == PH_COMMENT)
            begin
                if (ch == CH_CR)
                    phase = PH_BEGIN;
                stop = 1'b1;
            end
            if (!stop && phase == PH_BEGIN)
            begin
                phase    = PH_PRE;
                name_cnt = 0;
            end
            if (!stop && phase == PH_PRE)
            begin
                if (ch == CH_CR)
                begin
                    phase = PH_BEGIN;
                    stop  = 1'b1;
                end
                else if (ch == CH_SEMI)
                begin
                    phase = PH_COMMENT;
                    stop  = 1'b1;
                end
                else if (ch > CH_BLANK)
                    phase = PH_GET;
            end
            if (!stop && phase == PH_GET)
            begin
                if (ch == CH_CR)
                begin
                    err  = ST_FORMAT;
                    stop = 1'b1;
                end
                else if (ch <= CH_BLANK)
                    phase = PH_POST;
                else if (ch == CH_EQ)
                begin
                    phase = PH_MATCH;
                    stop  = 1'b1;
                end
                else
                begin
                    // drop name characters past the limit
                    if (name_cnt < NAME_MAX_DEF)
                    begin
                        name_buf[name_cnt] = ch;
                        name_cnt++;
                    end
                    stop = 1'b1;
                end
            end
            if (!stop && phase == PH_POST)
            begin
                if (ch == CH_CR || (ch > CH_BLANK && ch != CH_EQ))
                begin
                    err  = ST_FORMAT;
                    stop = 1'b1;
                end
                else if (ch == CH_EQ)
                begin
                    phase = PH_MATCH;
                    stop  = 1'b1;
                end
            end
            // keyword compare happens on the byte after '=', which is then
            // parsed as value text in the same step
            if (!stop && phase == PH_MATCH)
            begin
                val_cnt = 0;
                phase   = PH_VPRE;
                if (name_is("FILE"))
                    key = KEY_FILE;
                else if (name_is("TYPE"))
                    key = KEY_TYPE;
                else
                begin
                    err  = ST_UNKNOWN;
                    stop = 1'b1;
                end
                clr = !stop;
            end
            if (!stop && phase == PH_VPRE)
            begin
                if (ch == CH_CR)
                    fin = 1'b1;
                else if (ch <= CH_BLANK)
                    stop = 1'b1;
                else
                    phase = PH_VGET;
            end
            if (!stop && !fin && phase == PH_VGET)
            begin
                if (ch == CH_CR)
                    fin = 1'b1;
                else if (ch <= CH_BLANK)
                    phase = PH_VPOST;
                else
                begin
                    lim = (key == KEY_TYPE) ? TYPE_VALUE_MAX_DEF : FILE_VALUE_MAX_DEF;
                    if (lim > 63)
                        lim = 63;
                    if (val_cnt < lim)
                    begin
                        cv          = 1'b1;
                        r.char_pos  = val_cnt[5:0];
                        r.char_out  = ch;
                        val_cnt++;
                    end
                end
            end
            if (!stop && !fin && phase == PH_VPOST)
            begin
                if (ch == CH_CR)
                    fin = 1'b1;
                else if (ch > CH_BLANK)
                begin
                    err  = ST_FORMAT;
                    stop = 1'b1;
                end
            end
            if (!stop && fin)
                phase = PH_BEGIN;
            r.status      = err;
            r.key_cleared = clr;
            r.char_valid  = cv;
            r.line_done   = fin;
            r.key_index   = (clr || cv || fin) ? key : 1'b0;
            return r;
        endfunction

        function void note_byte(logic [7:0] ch);
            result_t r;
            r = parse_byte(ch);
            n_bytes++;
            n_clears += r.key_cleared;
            n_chars  += r.char_valid;
            n_lines  += r.line_done;
            due_q.push_back(r);
        endfunction

        task check_field(string f, logic [7:0] got, logic [7:0] want);
            if (got !== want)
                report($sformatf("%s got 0x%0h expected 0x%0h", f, got, want));
        endtask

        task check_result(result_t got);
            result_t want;
            if (due_q.size() == 0)
            begin
                report("result word with nothing pending");
                return;
            end
            want = due_q.pop_front();
            check_field("status",      8'(got.status),      8'(want.status));
            check_field("key_cleared", 8'(got.key_cleared), 8'(want.key_cleared));
            check_field("key_index",   8'(got.key_index),   8'(want.key_index));
            check_field("char_valid",  8'(got.char_valid),  8'(want.char_valid));
            check_field("char_pos",    8'(got.char_pos),    8'(want.char_pos));
            check_field("char_out",    got.char_out,        want.char_out);
            check_field("line_done",   8'(got.line_done),   8'(want.line_done));
        endtask

        function int pending();
            return due_q.size();
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte   = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] status;
    logic       key_cleared;
    logic       key_index;
    logic       char_valid;
    logic [5:0] char_pos;
    logic [7:0] char_out;
    logic       line_done;

    parser_scoreboard sb = new();

    bit quiet_tail    = 1'b0;
    bit long_hold_req = 1'b0;
    int idle_pct      = 0;
    int bytes_sent    = 0;
    int idle_cnt      = 0;

    key_value_line_parser_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .key_cleared (key_cleared),
        .key_index   (key_index),
        .char_valid  (char_valid),
        .char_pos    (char_pos),
        .char_out    (char_out),
        .line_done   (line_done)
    );

    always #5 clk = ~clk;

    // Note accepted bytes before checking results in the same edge
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(in_byte);
            if (out_valid && out_ready)
            begin
                got.status      = status;
                got.key_cleared = key_cleared;
                got.key_index   = key_index;
                got.char_valid  = char_valid;
                got.char_pos    = char_pos;
                got.char_out    = char_out;
                got.line_done   = line_done;
                sb.check_result(got);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cnt = 0;
            else
                idle_cnt++;
            if (idle_cnt >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side: random stall bursts, calm stretches and one long hold-off
    initial
    begin : sink
        int hold_left;
        int calm_left;
        hold_left = 0;
        calm_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (quiet_tail || calm_left > 0)
            begin
                out_ready <= 1'b1;
                if (calm_left > 0)
                    calm_left--;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0, 1:
                    begin
                        out_ready <= 1'b0;
                        hold_left = $urandom_range(0, 9);
                    end
                    2:
                    begin
                        out_ready <= 1'b1;
                        calm_left = $urandom_range(20, 80);
                    end
                    default: out_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic send_byte(logic [7:0] b);
        int gap;
        if (!quiet_tail && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_byte  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] rand_blank();
        logic [7:0] v;
        do
            v = 8'($urandom_range(0, 32));
        while (v == CH_CR);
        return v;
    endfunction

    task automatic send_blanks(int max_n);
        int n;
        n = $urandom_range(0, max_n);
        repeat (n) send_byte(rand_blank());
    endtask

    // One random well-formed line: blank, comment or FILE/TYPE assignment
    task automatic send_random_line();
        string      kw;
        logic [7:0] c;
        int         kind;
        int         vlen;
        kind = $urandom_range(0, 99);
        send_blanks(2);
        if (kind < 10)
        begin
            send_blanks(2);
        end
        else if (kind < 22)
        begin
            send_byte(CH_SEMI);
            repeat ($urandom_range(0, 12))
            begin
                do
                    c = 8'($urandom_range(0, 255));
                while (c == CH_CR);
                send_byte(c);
            end
        end
        else
        begin
            kw = $urandom_range(0, 1) ? "TYPE" : "FILE";
            for (int i = 0; i < kw.len(); i++)
            begin
                c = kw[i];
                if ($urandom_range(0, 1))
                    c = c + CASE_OFS;
                send_byte(c);
            end
            send_blanks(2);
            send_byte(CH_EQ);
            send_blanks(2);
            vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 70)
                                               : $urandom_range(0, 12);
            repeat (vlen) send_byte(8'($urandom_range(33, 255)));
            send_blanks(2);
        end
        send_byte(CH_CR);
    endtask

    task automatic send_fault(fault_kind_e kind);
        case (kind)
            BAD_CR_IN_NAME:       send_text("FIL");
            BAD_TEXT_AFTER_NAME:  send_text("FILE X");
            BAD_TEXT_AFTER_VALUE: send_text("type = ab c");
            BAD_CR_BEFORE_EQ:     send_text("FILE ");
            BAD_UNKNOWN_KEY:      send_text("NAME=x");
            BAD_LONG_NAME:        send_text("FILETYPE=x");
            BAD_EMPTY_NAME:       send_text("=x");
            default:              send_text("=x");
        endcase
        send_byte(CH_CR);
    endtask

    initial
    begin : stimulus
        fault_kind_e fault;
        bit          held;
        held = 1'b0;
        repeat (3) @(negedge clk);
        rst_n = 1'b1;

        // Directed: comment with extreme bytes, empty line, empty value,
        // then a TYPE value with high bytes and a trailing blank
        idle_pct = 0;
        send_byte(8'd32);
        send_byte(CH_SEMI);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CH_CR);
        send_byte(CH_CR);
        send_text("fIlE=");
        send_byte(CH_CR);
        send_text("TYPE =");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'd32);
        send_byte(8'h00);
        send_byte(CH_CR);

        while (bytes_sent < RANDOM_BYTES)
        begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 5;
                default: idle_pct = 25;
            endcase
            if (bytes_sent >= QUIET_AFTER)
                quiet_tail = 1'b1;
            if (!held && bytes_sent >= 400)
            begin
                // back up the output while bytes keep coming
                long_hold_req = 1'b1;
                held          = 1'b1;
            end
            send_random_line();
        end

        quiet_tail = 1'b1;
        fault = fault_kind_e'($urandom_range(0, 6));
        send_fault(fault);
        repeat (TAIL_NOISE) send_byte(8'($urandom_range(0, 255)));
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes: %0d keys cleared, %0d value characters, %0d lines closed",
                 sb.n_bytes, sb.n_clears, sb.n_chars, sb.n_lines);
        $display("Closing fault sequence %s left status %0d", fault.name(), sb.err);
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
